@@ rtl/core/fnp_pkg.sv @@
// Shared types and constants for the fractional-N frequency programmer.
package fnp_pkg;

  localparam int unsigned FreqW = 23;
  localparam int unsigned WordW = 32;
  localparam int unsigned DivW  = 3;
  localparam int unsigned NW    = 9;
  localparam int unsigned CfgIdxW = 3;

  // Lowest VCO frequency in kHz; divider search compares against it shifted down
  localparam logic [FreqW-1:0] VcoMinKhz = 23'd3000000;
  localparam int unsigned MaxDiv = 7;

  // N = scaled / 32000 = (scaled >> 8) / 125, done as multiply by reciprocal
  localparam int unsigned PfdShift = 8;
  localparam int unsigned QuotW    = FreqW - PfdShift;
  localparam int unsigned RecipW   = 16;
  localparam int unsigned RecipSh  = 22;
  localparam logic [RecipW-1:0] Recip125 = 16'd33555;
  localparam int unsigned RemW     = 7;
  localparam logic [NW-1:0] PfdOdd = 9'd125;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgReg1 = 3'd0,
    CfgReg2 = 3'd1,
    CfgReg3 = 3'd2,
    CfgReg4 = 3'd3,
    CfgReg5 = 3'd4
  } cfg_idx_e;

  // Register addresses framed into bits 2:0
  localparam logic [2:0] AddrR0 = 3'd0;
  localparam logic [2:0] AddrR1 = 3'd1;
  localparam logic [2:0] AddrR2 = 3'd2;
  localparam logic [2:0] AddrR3 = 3'd3;
  localparam logic [2:0] AddrR4 = 3'd4;
  localparam logic [2:0] AddrR5 = 3'd5;

  localparam logic [WordW-1:0] Reg1Rst = 32'h80008011;
  localparam logic [WordW-1:0] Reg2Rst = 32'h58011FC2;
  localparam logic [WordW-1:0] Reg3Rst = 32'h0100000B;
  localparam logic [WordW-1:0] Reg4Rst = 32'h608C8234;
  localparam logic [WordW-1:0] Reg5Rst = 32'h01400005;

  // Result of the divider calculation for one request
  typedef struct packed {
    logic [FreqW-1:0] scaled;
    logic [NW-1:0]    n;
    logic [DivW-1:0]  div;
    logic [FreqW-1:0] achieved;
  } calc_res_t;

  // Static register words held by the configuration port
  typedef struct packed {
    logic [WordW-1:0] reg1;
    logic [WordW-1:0] reg2;
    logic [WordW-1:0] reg3;
    logic [WordW-1:0] reg4;
    logic [WordW-1:0] reg5;
  } cfg_regs_t;

endpackage

@@ rtl/core/frac_n_pll_frequency_programmer.sv @@
// Top level of the fractional-N frequency programmer.
// Each accepted request (target frequency in kHz) yields six framed 32-bit
// register words, R5 first and R0 last, one per cycle while the output is not
// stalled; every word carries the achieved frequency and R0 is flagged as the
// last word. The request register feeds a single combinational pass (divider
// search, scaling, reciprocal multiply for N) into a result register; a
// request's first word is offered once it has passed the request register and
// then, when the result register is free, the result register. The six-word
// output sequence sets the sustained request rate; the next request is taken
// and computed while the current words drain.
// Configuration writes are always ready and take effect on the next cycle.
module frac_n_pll_frequency_programmer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fnp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fnp_pkg::WordW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fnp_pkg::FreqW-1:0]   target_khz_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fnp_pkg::WordW-1:0]   reg_word_o,
  output logic [fnp_pkg::FreqW-1:0]   achieved_khz_o,
  output logic                        last_word_o
);

  fnp_pkg::cfg_regs_t regs_q;
  logic                       in_vld_q, in_vld_d;
  logic [fnp_pkg::FreqW-1:0]  in_khz_q;
  logic                       in_acc;
  logic                       emit_free;
  logic                       load;
  fnp_pkg::calc_res_t         calc_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reg1 <= fnp_pkg::Reg1Rst;
      regs_q.reg2 <= fnp_pkg::Reg2Rst;
      regs_q.reg3 <= fnp_pkg::Reg3Rst;
      regs_q.reg4 <= fnp_pkg::Reg4Rst;
      regs_q.reg5 <= fnp_pkg::Reg5Rst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fnp_pkg::CfgReg1: regs_q.reg1 <= cfg_data_i;
        fnp_pkg::CfgReg2: regs_q.reg2 <= cfg_data_i;
        fnp_pkg::CfgReg3: regs_q.reg3 <= cfg_data_i;
        fnp_pkg::CfgReg4: regs_q.reg4 <= cfg_data_i;
        fnp_pkg::CfgReg5: regs_q.reg5 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the request while the result register is still sending words
  assign load       = in_vld_q && emit_free;
  assign in_stall_o = in_vld_q && !emit_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_khz_q <= target_khz_i;
    end
  end

  fnp_calc u_calc (
    .target_khz_i (in_khz_q),
    .res_o        (calc_res)
  );

  fnp_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .res_i          (calc_res),
    .regs_i         (regs_q),
    .free_o         (emit_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .reg_word_o     (reg_word_o),
    .achieved_khz_o (achieved_khz_o),
    .last_word_o    (last_word_o)
  );

endmodule

@@ rtl/core/fnp_calc.sv @@
// Divider search, request scaling and integer-N quotient for one request.
module fnp_calc (
  input  logic [fnp_pkg::FreqW-1:0] target_khz_i,
  output fnp_pkg::calc_res_t        res_o
);

  logic [fnp_pkg::DivW-1:0]        div;
  logic [fnp_pkg::FreqW+6:0]       wide;
  logic [fnp_pkg::FreqW-1:0]       scaled;
  logic [fnp_pkg::FreqW-1:0]       trunc;
  logic [fnp_pkg::QuotW+fnp_pkg::RecipW-1:0] prod;

  always_comb begin
    // Smallest exponent wins: walk downward so the last hit stands
    div = fnp_pkg::DivW'(fnp_pkg::MaxDiv);
    for (int d = fnp_pkg::MaxDiv - 1; d >= 0; d--) begin
      if (target_khz_i > (fnp_pkg::VcoMinKhz >> d)) begin
        div = fnp_pkg::DivW'(d);
      end
    end
  end

  assign wide   = {7'b0, target_khz_i} << div;
  assign scaled = wide[fnp_pkg::FreqW-1:0];
  assign prod   = (fnp_pkg::QuotW+fnp_pkg::RecipW)'(scaled[fnp_pkg::FreqW-1:fnp_pkg::PfdShift])
                * (fnp_pkg::QuotW+fnp_pkg::RecipW)'(fnp_pkg::Recip125);
  // 32000*N + 8*FRAC equals the scaled request with its low three bits dropped
  assign trunc  = {scaled[fnp_pkg::FreqW-1:3], 3'b000};

  assign res_o.scaled   = scaled;
  assign res_o.n        = prod[fnp_pkg::RecipSh +: fnp_pkg::NW];
  assign res_o.div      = div;
  assign res_o.achieved = trunc >> div;

endmodule

@@ rtl/core/fnp_emit.sv @@
// Result register and word sequencer: sends R5 down to R0 for each request.
module fnp_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  fnp_pkg::calc_res_t        res_i,
  input  fnp_pkg::cfg_regs_t        regs_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [fnp_pkg::WordW-1:0] reg_word_o,
  output logic [fnp_pkg::FreqW-1:0] achieved_khz_o,
  output logic                      last_word_o
);

  fnp_pkg::calc_res_t res_q;
  logic               vld_q, vld_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               last;
  logic [fnp_pkg::NW-1:0]   n_x125;
  logic [fnp_pkg::RemW-1:0] rem_hi;
  logic [fnp_pkg::WordW-1:0] word0;
  logic [fnp_pkg::WordW-1:0] word4;

  assign last   = (cnt_q == fnp_pkg::AddrR0);
  assign free_o = !vld_q || (last && !out_stall_i);

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (load_i) begin
      vld_d = 1'b1;
      cnt_d = fnp_pkg::AddrR5;
    end else if (vld_q && !out_stall_i) begin
      if (last) begin
        vld_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= fnp_pkg::AddrR5;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  // Remainder of the 125 division; bits 7:3 of the scaled request pass through below it
  assign n_x125 = fnp_pkg::NW'(res_q.n * fnp_pkg::PfdOdd);
  assign rem_hi = fnp_pkg::RemW'(res_q.scaled[fnp_pkg::FreqW-1:fnp_pkg::PfdShift]
                                 - {6'b0, n_x125});
  assign word0  = {8'b0, res_q.n, rem_hi, res_q.scaled[7:3], fnp_pkg::AddrR0};
  assign word4  = {regs_i.reg4[31:23], res_q.div, regs_i.reg4[19:3], fnp_pkg::AddrR4};

  always_comb begin
    case (cnt_q)
      fnp_pkg::AddrR5: reg_word_o = {regs_i.reg5[31:3], fnp_pkg::AddrR5};
      fnp_pkg::AddrR4: reg_word_o = word4;
      fnp_pkg::AddrR3: reg_word_o = {regs_i.reg3[31:3], fnp_pkg::AddrR3};
      fnp_pkg::AddrR2: reg_word_o = {regs_i.reg2[31:3], fnp_pkg::AddrR2};
      fnp_pkg::AddrR1: reg_word_o = {regs_i.reg1[31:3], fnp_pkg::AddrR1};
      fnp_pkg::AddrR0: reg_word_o = word0;
      default:         reg_word_o = word0;
    endcase
  end

  assign out_valid_o    = vld_q;
  assign achieved_khz_o = res_q.achieved;
  assign last_word_o    = last;

endmodule
